// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sst_pkg.sv =====
// Package: sizes, codes and beat types of the sorted set table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  // storage size and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNTR_W = $clog2(DEPTH + 1);

  // field widths
  localparam int VAL_W  = 32;
  localparam int OPC_W  = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CFG_W  = 7;
  localparam int CMP_W  = (CNTR_W > CFG_W) ? CNTR_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

  // opcodes
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } out_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    capture;
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

// ===== src/sst_cell.sv =====
// One slot of the sorted chain: holds a value, compares it, shifts with neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sst_cell import sst_pkg::*; (
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic                    occ,
  input  wire logic                    left_lt,
  input  wire logic signed [VAL_W-1:0] left_val,
  input  wire logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0]      val,
  output logic                         lt,
  output logic                         eq
);

  logic signed [VAL_W-1:0] val_r;
  logic                    lt_r;
  logic                    eq_r;

  // compare flags, only meaningful for occupied slots
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lt_r <= occ & (val_r < cmd.key);
      eq_r <= occ & (val_r == cmd.key);
    end
  end

  // insert: slots at or above the gap move up; remove: they pull from the right
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt_r) begin
      val_r <= left_lt ? cmd.key : left_val;
    end else if (cmd.rem && !lt_r) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

`default_nettype wire

// ===== src/sst_encode.sv =====
// One-hot to binary index encoder for the chain's boundary flags.
`timescale 1ns / 1ps
`default_nettype none

module sst_encode import sst_pkg::*; (
  input  wire logic [DEPTH-1:0] onehot,
  output logic [IDX_W-1:0]      index
);

  // OR of the slot numbers whose flag is set
  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_set_table.sv =====
// Top level: sorted set of signed values kept in a chain of compare/shift cells.
//
// Usage:
//   Command channel: present in_item (opcode, value) with start high; the beat
//   is taken at a rising edge where busy is low. Opcodes: insert, remove,
//   membership query.
//   Result channel: out_valid is high for exactly one cycle with out_item
//   (status, position, count after the item). The receiver cannot stall.
//   Config: cfg_we with cfg_wdata writes the capacity limit; write only while
//   idle. The usable capacity is the smaller of the limit and 64.
// Sequence:
//   After the accepting edge, all cells compare against the key in ST_CMP; in
//   ST_APPLY the position is encoded, the cells shift and the result register
//   loads. busy drops in the strobe cycle, so a new command is taken only once
//   the result of the last one is shown.
// Reset:
//   rst_n (synchronous, active low) empties the set and sets the limit to 64.
//   Cell contents are not cleared; the count marks which cells hold values.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table import sst_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_t              in_item,
  output logic                  out_valid,
  output out_t                  out_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  state_t                  state_r, state_nxt;
  in_t                     req_r;
  logic [CFG_W-1:0]        limit_r;
  logic [CNTR_W-1:0]       count_r, count_nxt;
  logic                    out_valid_r;
  out_t                    out_r, out_nxt;
  cell_cmd_t               cmd;

  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        lt_v;
  logic [DEPTH-1:0]        eq_v;
  logic [DEPTH-1:0]        bound;
  logic signed [VAL_W-1:0] vals [DEPTH];
  logic [IDX_W-1:0]        idx;

  logic                    hit;
  logic                    full;
  logic [CMP_W-1:0]        cap;
  logic                    ins_ok;
  logic                    rem_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // match detection and capacity check
  assign hit  = |eq_v;
  assign cap  = (CMP_W'(limit_r) < CMP_W'(DEPTH)) ? CMP_W'(limit_r) : CMP_W'(DEPTH);
  assign full = CMP_W'(count_r) >= cap;

  // outputs of the control
  always_comb begin
    busy        = (state_r != ST_IDLE);
    cmd.capture = (state_r == ST_CMP);
    cmd.key     = req_r.value;
    ins_ok      = 1'b0;
    rem_ok      = 1'b0;
    count_nxt   = count_r;
    out_nxt.status   = STAT_ABSENT;
    out_nxt.position = '0;
    case (req_r.opcode)
      OP_INSERT: begin
        if (hit) begin
          out_nxt.status   = STAT_DUP;
          out_nxt.position = POS_W'(idx);
        end else if (full) begin
          out_nxt.status = STAT_FULL;
        end else begin
          ins_ok           = 1'b1;
          count_nxt        = count_r + CNTR_W'(1);
          out_nxt.status   = STAT_OK;
          out_nxt.position = POS_W'(idx);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          rem_ok           = 1'b1;
          count_nxt        = count_r - CNTR_W'(1);
          out_nxt.status   = STAT_OK;
          out_nxt.position = POS_W'(idx);
        end
      end
      OP_QUERY: begin
        if (hit) begin
          out_nxt.status   = STAT_OK;
          out_nxt.position = POS_W'(idx);
        end
      end
      default: begin
      end
    endcase
    out_nxt.count = CNT_W'(count_nxt);
    cmd.ins = (state_r == ST_APPLY) & ins_ok;
    cmd.rem = (state_r == ST_APPLY) & rem_ok;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_APPLY);
      if (state_r == ST_APPLY) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r <= in_item;
    end
    if (state_r == ST_APPLY) begin
      out_r <= out_nxt;
    end
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = count_r > CNTR_W'(g);
    if (g == 0) begin : g_first
      assign bound[g] = ~lt_v[g];
    end else begin : g_rest
      assign bound[g] = lt_v[g-1] & ~lt_v[g];
    end

    sst_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[g]),
      .left_lt   ((g == 0) ? 1'b1 : lt_v[(g == 0) ? 0 : g-1]),
      .left_val  (vals[(g == 0) ? 0 : g-1]),
      .right_val (vals[(g == DEPTH-1) ? g : g+1]),
      .val       (vals[g]),
      .lt        (lt_v[g]),
      .eq        (eq_v[g])
    );
  end

  // position of the first slot not below the key
  sst_encode u_encode (
    .onehot (bound),
    .index  (idx)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== src/sst_checker.sv =====
// Port-level checker for the sorted set table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sst_checker import sst_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_item
);

  // every accepted command is followed by its result strobe
  `SST_ASSERT_IMP(a_latency, start && !busy, ##3 out_valid, "result strobe missing")
  // the result strobe lasts one cycle per command
  `SST_ASSERT_NXT(a_single, out_valid, !out_valid, "result strobe repeated")
  // the block is free again while its result is shown
  `SST_ASSERT_IMP(a_free, out_valid, !busy, "busy during result beat")
  // a refused insert reports no position
  `SST_ASSERT_IMP(a_full_pos, out_valid && out_item.status == STAT_FULL,
    out_item.position == '0, "full status with nonzero position")
  // the count never exceeds the storage
  `SST_ASSERT_IMP(a_count, out_valid, out_item.count <= DEPTH, "count beyond storage")

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ===== tb/set_table_checker.sv =====
// Checker for the sorted set table: keeps a shadow set, predicts each result and compares.
`timescale 1ns / 1ps

module set_table_checker import sst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_t              in_item,
  input  logic             out_valid,
  input  out_t             out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               outstanding,
  output int               mismatches
);

  // shadow copy of the set: ascending values, count and capacity limit
  logic signed [VAL_W-1:0] shadow_vals [DEPTH];
  int                      shadow_n;
  logic [CFG_W-1:0]        shadow_cap;

  // predicted outcomes of accepted beats, oldest first
  out_t pending_outcomes [$];
  out_t oldest;
  int   bad = 0;

  // Apply one command to the shadow set and return the outcome it should report.
  function automatic out_t apply_set_op(in_t beat);
    logic signed [VAL_W-1:0] key;
    int   below;
    int   room;
    bit   hit;
    out_t res;
    key   = beat.value;
    below = 0;
    hit   = 1'b0;
    // signed compare against every held value
    for (int i = 0; i < shadow_n; i++) begin
      if (shadow_vals[i] < key) below++;
      else if (shadow_vals[i] == key) hit = 1'b1;
    end
    room         = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
    res.status   = STAT_ABSENT;
    res.position = '0;
    case (beat.opcode)
      OP_INSERT: begin
        if (hit) begin
          res.status   = STAT_DUP;
          res.position = POS_W'(below);
        end else if (shadow_n >= room) begin
          res.status = STAT_FULL;
        end else begin
          // open a slot: larger values move up one place
          for (int i = shadow_n; i > below; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[below] = key;
          shadow_n++;
          res.status   = STAT_OK;
          res.position = POS_W'(below);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          // close the gap
          for (int i = below; i + 1 < shadow_n; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_n--;
          res.status   = STAT_OK;
          res.position = POS_W'(below);
        end
      end
      OP_QUERY: begin
        if (hit) begin
          res.status   = STAT_OK;
          res.position = POS_W'(below);
        end
      end
      default: ;  // unused opcode leaves the set alone
    endcase
    res.count = CNT_W'(shadow_n);
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      bad++;
    end
  endfunction

  // Watch config writes, result strobes and accepted beats on each edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_n   = 0;
      shadow_cap = CAP_RESET;
      pending_outcomes.delete();
    end else begin
      if (cfg_we) shadow_cap = cfg_wdata;
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d position %0d count %0d",
                   $time, out_item.status, out_item.position, out_item.count);
          bad++;
        end else begin
          oldest = pending_outcomes.pop_front();
          check_field("status", oldest.status, out_item.status);
          check_field("position", oldest.position, out_item.position);
          check_field("count", oldest.count, out_item.count);
        end
      end
      if (start && !busy) pending_outcomes.push_back(apply_set_op(in_item));
    end
    outstanding <= pending_outcomes.size();
    mismatches  <= bad;
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, command stimulus, capacity settings and the verdict.
`timescale 1ns / 1ps

module testbench;
  import sst_pkg::*;

  localparam logic [OPC_W-1:0]     OP_UNUSED    = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'h7fff_ffff;
  localparam int                   POOL_N       = 96;
  localparam int                   N_PHASES     = 9;
  localparam int                   PHASE_ITEMS  = 190;
  localparam int                   DRAIN_CYCLES = 8;
  localparam int                   WAIT_LIMIT   = 1000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              in_item   = '0;
  logic             out_valid;
  out_t             out_item;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               outstanding;
  int               mismatches;

  // values that recur so inserts, removes and queries hit each other
  logic signed [VAL_W-1:0] pool [POOL_N];
  int burst_left;
  int wait_cycles;
  int op_roll;
  logic [OPC_W-1:0] op;

  // per phase: capacity limit, insert and remove percentages
  int phase_cap [N_PHASES] = '{64, 127, 1, 0, 40, 12, 64, 2, 64};
  int phase_ins [N_PHASES] = '{75, 45, 50, 30, 80, 40, 85, 40, 10};
  int phase_rem [N_PHASES] = '{15, 40, 30, 40, 10, 40, 5, 40, 70};

  always #5 clk = ~clk;

  sorted_set_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  set_table_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Present one command beat and hold it until taken; most bursts end in a random gap.
  task automatic send_beat(input logic [OPC_W-1:0] opc, input logic signed [VAL_W-1:0] v);
    in_item <= '{opcode: opc, value: v};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Capacity writes only once the table has drained.
  task automatic write_limit(input int lim);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wdata <= CFG_W'(lim);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 88) return pool[$urandom_range(POOL_N - 1)];
    return $urandom;
  endfunction

  // Global timeout
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    pool[0] = VAL_MIN;
    pool[1] = VAL_MIN + 1;
    pool[2] = VAL_MAX;
    pool[3] = VAL_MAX - 1;
    pool[4] = '0;
    pool[5] = '1;
    for (int i = 6; i < POOL_N; i++) pool[i] = $urandom;
    burst_left = $urandom_range(1, 24);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes at both ends, duplicate, misses, unused opcode
    send_beat(OP_QUERY, VAL_MIN);
    send_beat(OP_REMOVE, VAL_MIN);
    send_beat(OP_INSERT, 0);
    send_beat(OP_INSERT, VAL_MIN);
    send_beat(OP_INSERT, VAL_MAX);
    send_beat(OP_INSERT, -1);
    send_beat(OP_INSERT, 1);
    send_beat(OP_INSERT, 0);
    send_beat(OP_QUERY, VAL_MAX);
    send_beat(OP_QUERY, 5);
    send_beat(OP_UNUSED, 0);
    send_beat(OP_REMOVE, VAL_MIN);
    send_beat(OP_REMOVE, VAL_MAX);
    send_beat(OP_REMOVE, 7);
    // full set, duplicate while full, zero limit, limit above the depth
    write_limit(3);
    send_beat(OP_INSERT, 9);
    send_beat(OP_INSERT, -1);
    write_limit(0);
    send_beat(OP_INSERT, 100);
    send_beat(OP_QUERY, 1);
    write_limit(127);
    send_beat(OP_INSERT, VAL_MAX - 1);
    send_beat(OP_INSERT, VAL_MIN + 1);
    send_beat(OP_REMOVE, 0);

    // random phases, each under its own capacity limit and op mix
    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_cap[p]);
      repeat (PHASE_ITEMS) begin
        op_roll = $urandom_range(99);
        if (op_roll < phase_ins[p]) op = OP_INSERT;
        else if (op_roll < phase_ins[p] + phase_rem[p]) op = OP_REMOVE;
        else if (op_roll < 98) op = OP_QUERY;
        else op = OP_UNUSED;
        send_beat(op, pick_value());
      end
    end

    // drain and verdict
    start <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < WAIT_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
